### sv/chacha_pkg.sv
package chacha_pkg;

    // Data path and configuration widths.
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 4;

    // Rounds; an odd count runs as one more, since rounds go in column/diagonal pairs.
    localparam int ROUND_COUNT = 20;
    localparam int NUM_HALF    = 2 * ((ROUND_COUNT + 1) / 2);
    localparam int HALF_W      = $clog2(NUM_HALF);

    typedef logic [WORD_W-1:0]       t_word;
    typedef logic [15:0][WORD_W-1:0] t_words;
    typedef logic [3:0][WORD_W-1:0]  t_lanes;

    // Block function constants ("expand 32-byte k").
    localparam t_word SIGMA0 = 32'h6170_7865;
    localparam t_word SIGMA1 = 32'h3320_646E;
    localparam t_word SIGMA2 = 32'h7962_2D32;
    localparam t_word SIGMA3 = 32'h6B20_6574;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CTR      = 3'd6;

    // Quarter-round steps: add, xor, rotate by the named amount.
    localparam logic [1:0] STEP_AB16 = 2'd0;
    localparam logic [1:0] STEP_CD12 = 2'd1;
    localparam logic [1:0] STEP_AB8  = 2'd2;
    localparam logic [1:0] STEP_CD7  = 2'd3;

    // Status of the block function engine.
    typedef struct packed {
        logic busy;
        logic done;
    } t_blk_stat;

endpackage

### sv/chacha_in_if.sv
interface chacha_in_if import chacha_pkg::*;;
    logic  valid;
    logic  ready;
    t_word plaintext_word;

    modport source (output valid, output plaintext_word, input ready);
    modport sink   (input valid, input plaintext_word, output ready);
endinterface

### sv/chacha_out_if.sv
interface chacha_out_if import chacha_pkg::*;;
    logic             valid;
    logic             ready;
    t_word            ciphertext_word;
    logic [POS_W-1:0] word_in_block;
    logic             block_end;

    modport source (output valid, output ciphertext_word, output word_in_block,
                    output block_end, input ready);
    modport sink   (input valid, input ciphertext_word, input word_in_block,
                    input block_end, output ready);
endinterface

### sv/chacha_arx.sv
module chacha_arx import chacha_pkg::*; (
    input  logic [1:0] i_step,
    input  t_lanes     i_p,
    input  t_lanes     i_q,
    input  t_lanes     i_r,
    output t_lanes     o_sum,
    output t_lanes     o_mix
);

    t_lanes v_sum;
    t_lanes v_x;

    // Four independent lanes: sum = p + q, mix = rotl(r ^ sum, amount of the step).
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            v_sum[k] = i_p[k] + i_q[k];
            v_x[k]   = i_r[k] ^ v_sum[k];
            case (i_step)
                STEP_AB16: o_mix[k] = {v_x[k][15:0], v_x[k][31:16]};
                STEP_CD12: o_mix[k] = {v_x[k][19:0], v_x[k][31:20]};
                STEP_AB8:  o_mix[k] = {v_x[k][23:0], v_x[k][31:24]};
                STEP_CD7:  o_mix[k] = {v_x[k][24:0], v_x[k][31:25]};
                default:   o_mix[k] = v_x[k];
            endcase
        end
        o_sum = v_sum;
    end

endmodule

### sv/chacha_block.sv
module chacha_block import chacha_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_words           i_init,
    input  logic [POS_W-1:0] i_rd_idx,
    output t_blk_stat        o_stat,
    output t_word            o_rd_word
);

    t_words            r_w;
    t_words            n_w;
    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [HALF_W-1:0] r_half;

    logic              v_diag;
    logic [3:0][1:0]   v_ib;
    logic [3:0][1:0]   v_ic;
    logic [3:0][1:0]   v_id;
    t_lanes            v_a;
    t_lanes            v_b;
    t_lanes            v_c;
    t_lanes            v_d;
    t_lanes            v_p;
    t_lanes            v_q;
    t_lanes            v_r;
    t_lanes            v_sum;
    t_lanes            v_mix;

    // Gather the four quarter-round lanes; diagonal rounds rotate rows b, c, d.
    always_comb begin
        v_diag = r_half[0];
        for (int k = 0; k < 4; k++) begin
            v_ib[k] = 2'(k) + {1'b0, v_diag};
            v_ic[k] = 2'(k) + {v_diag, 1'b0};
            v_id[k] = 2'(k) + {v_diag, v_diag};
            v_a[k]  = r_w[{2'b00, 2'(k)}];
            v_b[k]  = r_w[{2'b01, v_ib[k]}];
            v_c[k]  = r_w[{2'b10, v_ic[k]}];
            v_d[k]  = r_w[{2'b11, v_id[k]}];
        end
        if (!r_step[0]) begin
            v_p = v_a;
            v_q = v_b;
            v_r = v_d;
        end else begin
            v_p = v_c;
            v_q = v_d;
            v_r = v_b;
        end
    end

    chacha_arx u_arx (
        .i_step (r_step),
        .i_p    (v_p),
        .i_q    (v_q),
        .i_r    (v_r),
        .o_sum  (v_sum),
        .o_mix  (v_mix)
    );

    // Scatter the results back to the rows they came from.
    always_comb begin
        n_w = r_w;
        for (int k = 0; k < 4; k++) begin
            if (!r_step[0]) begin
                n_w[{2'b00, 2'(k)}]  = v_sum[k];
                n_w[{2'b11, v_id[k]}] = v_mix[k];
            end else begin
                n_w[{2'b10, v_ic[k]}] = v_sum[k];
                n_w[{2'b01, v_ib[k]}] = v_mix[k];
            end
        end
    end

    // Step sequencer: four steps per half round, NUM_HALF half rounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_half <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_half <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_CD7) begin
                    if (r_half == HALF_W'(NUM_HALF - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_half <= r_half + 1'b1;
                    end
                end
            end
        end
    end

    // Working state.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_init;
        end else if (r_busy) begin
            r_w <= n_w;
        end
    end

    assign o_rd_word = r_w[i_rd_idx];
    assign o_stat    = '{busy: r_busy, done: r_done};

endmodule

### sv/chacha20_stream_cipher_core.sv
// A word at position 0 of a block starts the block function; its result is loaded into
// the output register once the shared four-lane ARX unit has run all its steps (four per
// half round, NUM_HALF half rounds) and the done flag is seen. Other words are loaded into
// the output register as they are accepted. No new word is accepted while the block
// function runs or while its result waits to be loaded.
// Reset: synchronous, active low; clears configuration to zero, position 0, counter 0.
module chacha20_stream_cipher_core import chacha_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    chacha_in_if.sink            i_data,
    chacha_out_if.source         o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [3:0][CFG_W-1:0] r_key;
    logic [CFG_W-1:0]      r_nonce_lo;
    t_word                 r_nonce_hi;
    t_word                 r_ctr_init;
    t_word                 r_blk_ctr;
    logic [POS_W-1:0]      r_pos;
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    t_word                 r_pt;
    logic                  r_out_valid;
    t_word                 r_ct;
    logic [POS_W-1:0]      r_wib;
    logic                  r_end;

    logic                  v_slot_free;
    logic                  v_accept;
    logic                  v_start;
    logic                  v_load;
    logic                  v_cfg_valid;
    t_words                v_init;
    logic [POS_W-1:0]      v_idx;
    t_word                 v_ks;
    t_word                 v_src;
    t_blk_stat             blk_stat;
    t_word                 blk_word;

    // Handshake: accept while idle and the output register is free or being emptied.
    assign v_slot_free   = !r_out_valid || o_data.ready;
    assign i_data.ready  = (r_state == S_IDLE) && v_slot_free;
    assign v_accept      = i_data.valid && i_data.ready;
    assign v_start       = v_accept && (r_pos == '0);
    assign v_cfg_valid   = i_cfg_we && (i_cfg_idx <= REG_CTR);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_ctr_init <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0:     r_key[0]   <= i_cfg_data;
                REG_KEY1:     r_key[1]   <= i_cfg_data;
                REG_KEY2:     r_key[2]   <= i_cfg_data;
                REG_KEY3:     r_key[3]   <= i_cfg_data;
                REG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                REG_NONCE_HI: r_nonce_hi <= i_cfg_data[WORD_W-1:0];
                REG_CTR:      r_ctr_init <= i_cfg_data[WORD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Word position and block counter; a valid configuration write restarts the stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_blk_ctr <= '0;
        end else if (v_cfg_valid) begin
            r_pos     <= '0;
            r_blk_ctr <= (i_cfg_idx == REG_CTR) ? i_cfg_data[WORD_W-1:0] : r_ctr_init;
        end else if (v_accept) begin
            r_pos <= r_pos + 1'b1;
            if (r_pos == '1) begin
                r_blk_ctr <= r_blk_ctr + 32'd1;
            end
        end
    end

    // Input state of the block function.
    always_comb begin
        v_init[0] = SIGMA0;
        v_init[1] = SIGMA1;
        v_init[2] = SIGMA2;
        v_init[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            v_init[4 + 2 * i] = r_key[i][WORD_W-1:0];
            v_init[5 + 2 * i] = r_key[i][CFG_W-1:WORD_W];
        end
        v_init[12] = r_blk_ctr;
        v_init[13] = r_nonce_lo[WORD_W-1:0];
        v_init[14] = r_nonce_lo[CFG_W-1:WORD_W];
        v_init[15] = r_nonce_hi;
    end

    chacha_block u_block (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (v_start),
        .i_init    (v_init),
        .i_rd_idx  (v_idx),
        .o_stat    (blk_stat),
        .o_rd_word (blk_word)
    );

    // Sequencer for the block function at word 0.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (v_start) n_state = S_RUN;
            S_RUN:   if (blk_stat.done) n_state = S_FIN;
            S_FIN:   if (v_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the first word of a block while its keystream is generated.
    always_ff @(posedge i_clk) begin
        if (v_start) begin
            r_pt <= i_data.plaintext_word;
        end
    end

    // Keystream word: final state plus input state at the current position.
    assign v_idx  = (r_state == S_IDLE) ? r_pos : '0;
    assign v_ks   = blk_word + v_init[v_idx];
    assign v_src  = (r_state == S_IDLE) ? i_data.plaintext_word : r_pt;
    assign v_load = (v_accept && (r_pos != '0)) || ((r_state == S_FIN) && v_slot_free);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (v_load) begin
            r_out_valid <= 1'b1;
        end else if (o_data.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load) begin
            r_ct  <= v_src ^ v_ks;
            r_wib <= v_idx;
            r_end <= (v_idx == '1);
        end
    end

    assign o_data.valid           = r_out_valid;
    assign o_data.ciphertext_word = r_ct;
    assign o_data.word_in_block   = r_wib;
    assign o_data.block_end       = r_end;

endmodule

### sv/chacha_checker.sv
module chacha_checker import chacha_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [POS_W-1:0] i_word_in_block,
    input logic             i_block_end,
    input t_word            i_ct
);

    // A stalled output word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ct)
            && $stable(i_word_in_block) && $stable(i_block_end))
        else $error("output word changed while stalled");

    // The end-of-block flag marks the last position only.
    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_block_end == (i_word_in_block == '1)))
        else $error("block end flag does not match word position");

    // No new input word while a finished word is held back.
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input ready while output is stalled");

    // After reset the output is empty and the input is open.
    a_reset_state: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("wrong handshake state after reset");

endmodule

bind chacha20_stream_cipher_core chacha_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_data.ready),
    .i_out_valid     (o_data.valid),
    .i_out_ready     (o_data.ready),
    .i_word_in_block (o_data.word_in_block),
    .i_block_end     (o_data.block_end),
    .i_ct            (o_data.ciphertext_word)
);
